[sv/clns_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_pkg: shared types and constants of the character LCD nibble sequencer
// Request kinds, register map, sequencer state and LCD command constants.
// ----------------------------------------------------------------------------
package clns_pkg;

	localparam int ModeW   = 3;
	localparam int ByteW   = 8;
	localparam int NibW    = 4;
	localparam int RowW    = 3;
	localparam int ColW    = 6;
	localparam int WaitW   = 2;
	localparam int StepW   = 4;
	localparam int AddrW   = 7;
	localparam int PaddrW  = 4;
	localparam int PdataW  = 32;

	typedef enum logic [ModeW-1:0] {
		MODE_INIT   = 3'd0,
		MODE_CMD    = 3'd1,
		MODE_CHAR   = 3'd2,
		MODE_ADDR   = 3'd3,
		MODE_CURSOR = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		REG_FUNCTION_SET    = 2'd0,
		REG_ENTRY_MODE      = 2'd1,
		REG_DISPLAY_CONTROL = 2'd2
	} reg_idx_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} seq_state_t;

	localparam logic [ByteW-1:0] FunctionSetRst    = 8'h28;
	localparam logic [ByteW-1:0] EntryModeRst      = 8'h06;
	localparam logic [ByteW-1:0] DisplayControlRst = 8'h0E;
	localparam logic [ByteW-1:0] CmdClear          = 8'h01;
	localparam logic [NibW-1:0]  NibWake           = 4'h3;
	localparam logic [NibW-1:0]  NibBus4           = 4'h2;
	localparam logic [ByteW-1:0] SetDdramBit       = 8'h80;

	localparam logic [AddrW-1:0] RowBase1 = 7'h00;
	localparam logic [AddrW-1:0] RowBase2 = 7'h40;
	localparam logic [AddrW-1:0] RowBase3 = 7'h14;
	localparam logic [AddrW-1:0] RowBase4 = 7'h54;

	localparam logic [WaitW-1:0] WaitLong  = 2'd3;
	localparam logic [WaitW-1:0] WaitShort = 2'd1;
	localparam logic [WaitW-1:0] WaitNone  = 2'd0;

	// init strobe sequence: 0..2 wake-up nibbles, 3 the 0x2 nibble, 4..11 four command bytes
	localparam logic [StepW-1:0] StepFirst    = 4'd0;
	localparam logic [StepW-1:0] StepWake2    = 4'd1;
	localparam logic [StepW-1:0] StepWake3    = 4'd2;
	localparam logic [StepW-1:0] StepBus4     = 4'd3;
	localparam logic [StepW-1:0] StepEntryLd  = 4'd5;
	localparam logic [StepW-1:0] StepDispLd   = 4'd7;
	localparam logic [StepW-1:0] StepClearLd  = 4'd9;
	localparam logic [StepW-1:0] StepLastByte = 4'd10;
	localparam logic [StepW-1:0] StepLast     = 4'd11;

	// clear, return home and entry-related codes 1..3 need a longer settle
	function automatic logic slow_cmd(input logic [ByteW-1:0] c);
		return (c == 8'd1) || (c == 8'd2) || (c == 8'd3);
	endfunction

endpackage

[sv/clns_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_req_if: request channel of the character LCD nibble sequencer
// Valid/ready channel carrying one LCD request.
// ----------------------------------------------------------------------------
interface clns_req_if;
	logic                       valid;
	logic                       ready;
	logic [clns_pkg::ModeW-1:0] mode;
	logic [clns_pkg::ByteW-1:0] value;
	logic [clns_pkg::RowW-1:0]  row;
	logic [clns_pkg::ColW-1:0]  column;

	modport source (output valid, mode, value, row, column, input ready);
	modport sink   (input valid, mode, value, row, column, output ready);
endinterface

[sv/clns_strobe_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_strobe_if: strobe channel of the character LCD nibble sequencer
// Valid/ready channel carrying one enable strobe for the LCD bus.
// ----------------------------------------------------------------------------
interface clns_strobe_if;
	logic                       valid;
	logic                       ready;
	logic                       reg_select;
	logic [clns_pkg::NibW-1:0]  nibble;
	logic [clns_pkg::WaitW-1:0] pre_wait_units;
	logic                       extra_settle;
	logic                       last_strobe;

	modport source (output valid, reg_select, nibble, pre_wait_units, extra_settle,
		last_strobe, input ready);
	modport sink   (input valid, reg_select, nibble, pre_wait_units, extra_settle,
		last_strobe, output ready);
endinterface

[sv/char_lcd_nibble_sequencer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core: 4-bit character LCD request sequencer
// Turns LCD requests into nibble strobes through a nibble shift register.
// ----------------------------------------------------------------------------
// Each request becomes a run of enable strobes, high nibble first, one strobe
// per cycle unless the sink stalls, into an output register that frees itself
// as the sink takes it. An init request gives twelve strobes (three wake-up 0x3,
// one 0x2, the three setup registers and a clear); command, character, set
// address and cursor requests give two. The next request is taken the cycle
// after the last strobe of the current one enters the output register; a cursor
// request with a bad row or column 0, or an unknown mode, gives no strobes and
// leaves the core ready for another request. The setup registers sit on an APB
// port at byte addresses 0, 4 and 8; the user must write them only while no
// request is in progress, as the core itself does not enforce this.
module char_lcd_nibble_sequencer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	clns_req_if.sink                      req_ch,
	clns_strobe_if.source                 strobe_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [clns_pkg::PaddrW-1:0]   paddr,
	input  logic [clns_pkg::PdataW-1:0]   pwdata,
	output logic [clns_pkg::PdataW-1:0]   prdata,
	output logic                          pready
);

	// setup registers
	logic [clns_pkg::ByteW-1:0] function_set_q;
	logic [clns_pkg::ByteW-1:0] entry_mode_q;
	logic [clns_pkg::ByteW-1:0] display_control_q;

	logic                          cfg_wr;
	clns_pkg::reg_idx_t            cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = clns_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			function_set_q    <= clns_pkg::FunctionSetRst;
			entry_mode_q      <= clns_pkg::EntryModeRst;
			display_control_q <= clns_pkg::DisplayControlRst;
		end else if (cfg_wr && (paddr[1:0] == 2'b00)) begin
			case (cfg_idx)
				clns_pkg::REG_FUNCTION_SET:    function_set_q    <= pwdata[7:0];
				clns_pkg::REG_ENTRY_MODE:      entry_mode_q      <= pwdata[7:0];
				clns_pkg::REG_DISPLAY_CONTROL: display_control_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			case (cfg_idx)
				clns_pkg::REG_FUNCTION_SET:    prdata[7:0] = function_set_q;
				clns_pkg::REG_ENTRY_MODE:      prdata[7:0] = entry_mode_q;
				clns_pkg::REG_DISPLAY_CONTROL: prdata[7:0] = display_control_q;
				default:                       prdata      = '0;
			endcase
		end
	end

	// request decode
	clns_pkg::seq_state_t          state_q, state_d;
	logic [clns_pkg::StepW-1:0]    step_q;
	logic [clns_pkg::ByteW-1:0]    sh_q;
	logic                          settle_q;
	logic                          rs_q;

	logic                          req_acc;
	logic                          req_go;
	logic [clns_pkg::AddrW-1:0]    row_base;
	logic                          row_ok;
	logic [clns_pkg::AddrW-1:0]    cur_addr;
	logic [clns_pkg::ByteW-1:0]    ld_byte;
	logic                          ld_settle;
	logic                          ld_rs;

	always_comb begin
		row_ok   = 1'b1;
		row_base = clns_pkg::RowBase1;
		case (req_ch.row)
			3'd1:    row_base = clns_pkg::RowBase1;
			3'd2:    row_base = clns_pkg::RowBase2;
			3'd3:    row_base = clns_pkg::RowBase3;
			3'd4:    row_base = clns_pkg::RowBase4;
			default: row_ok   = 1'b0;
		endcase
	end

	// one-based column, address wraps to 7 bits
	assign cur_addr = row_base + {1'b0, req_ch.column} - 7'd1;

	always_comb begin
		req_go    = 1'b1;
		ld_byte   = req_ch.value;
		ld_settle = 1'b0;
		ld_rs     = 1'b0;
		case (clns_pkg::mode_t'(req_ch.mode))
			clns_pkg::MODE_INIT: begin
				ld_byte   = function_set_q;
				ld_settle = clns_pkg::slow_cmd(function_set_q);
			end
			clns_pkg::MODE_CMD: begin
				ld_settle = clns_pkg::slow_cmd(req_ch.value);
			end
			clns_pkg::MODE_CHAR: begin
				ld_rs = 1'b1;
			end
			clns_pkg::MODE_ADDR: begin
				ld_byte = req_ch.value | clns_pkg::SetDdramBit;
			end
			clns_pkg::MODE_CURSOR: begin
				ld_byte = {1'b1, cur_addr};
				req_go  = row_ok && (req_ch.column != '0);
			end
			default: req_go = 1'b0;
		endcase
	end

	// strobe generation
	logic                          out_valid_q;
	logic                          out_rs_q;
	logic [clns_pkg::NibW-1:0]     out_nib_q;
	logic [clns_pkg::WaitW-1:0]    out_wait_q;
	logic                          out_settle_q;
	logic                          out_last_q;

	logic                          emit;
	logic                          emit_last;
	logic [clns_pkg::NibW-1:0]     emit_nib;
	logic [clns_pkg::WaitW-1:0]    emit_wait;
	logic                          emit_settle;

	assign req_ch.ready = (state_q == clns_pkg::ST_IDLE);
	assign req_acc      = req_ch.valid && req_ch.ready;
	assign emit         = (state_q == clns_pkg::ST_RUN) && (!out_valid_q || strobe_ch.ready);
	assign emit_last    = (step_q == clns_pkg::StepLast);

	always_comb begin
		state_d     = state_q;
		emit_nib    = sh_q[7:4];
		emit_wait   = clns_pkg::WaitNone;
		emit_settle = step_q[0] && settle_q;
		case (step_q)
			clns_pkg::StepFirst: begin
				emit_nib    = clns_pkg::NibWake;
				emit_wait   = clns_pkg::WaitLong;
				emit_settle = 1'b0;
			end
			clns_pkg::StepWake2, clns_pkg::StepWake3: begin
				emit_nib    = clns_pkg::NibWake;
				emit_wait   = clns_pkg::WaitShort;
				emit_settle = 1'b0;
			end
			clns_pkg::StepBus4: begin
				emit_nib    = clns_pkg::NibBus4;
				emit_settle = 1'b0;
			end
			default: ;
		endcase
		case (state_q)
			clns_pkg::ST_IDLE: if (req_acc && req_go) state_d = clns_pkg::ST_RUN;
			clns_pkg::ST_RUN:  if (emit && emit_last) state_d = clns_pkg::ST_IDLE;
			default:           state_d = clns_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clns_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (req_acc) begin
			step_q <= (req_ch.mode == clns_pkg::MODE_INIT) ? clns_pkg::StepFirst
				: clns_pkg::StepLastByte;
		end else if (emit) begin
			step_q <= step_q + 4'd1;
		end
	end

	// nibble shift register: high nibble out, shift, reload after the low nibble
	always_ff @(posedge clk) begin
		if (req_acc) begin
			sh_q     <= ld_byte;
			settle_q <= ld_settle;
			rs_q     <= ld_rs;
		end else if (emit && (step_q > clns_pkg::StepBus4)) begin
			case (step_q)
				clns_pkg::StepEntryLd: begin
					sh_q     <= entry_mode_q;
					settle_q <= clns_pkg::slow_cmd(entry_mode_q);
				end
				clns_pkg::StepDispLd: begin
					sh_q     <= display_control_q;
					settle_q <= clns_pkg::slow_cmd(display_control_q);
				end
				clns_pkg::StepClearLd: begin
					sh_q     <= clns_pkg::CmdClear;
					settle_q <= 1'b1;
				end
				default: sh_q <= {sh_q[3:0], 4'h0};
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (strobe_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_rs_q     <= rs_q;
			out_nib_q    <= emit_nib;
			out_wait_q   <= emit_wait;
			out_settle_q <= emit_settle;
			out_last_q   <= emit_last;
		end
	end

	assign strobe_ch.valid          = out_valid_q;
	assign strobe_ch.reg_select     = out_rs_q;
	assign strobe_ch.nibble         = out_nib_q;
	assign strobe_ch.pre_wait_units = out_wait_q;
	assign strobe_ch.extra_settle   = out_settle_q;
	assign strobe_ch.last_strobe    = out_last_q;

`ifndef SYNTH
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> (state_q == clns_pkg::ST_IDLE))
		else $error("sequencer still running after last strobe");

	a_init_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (req_ch.mode == clns_pkg::MODE_INIT))
		|=> ((state_q == clns_pkg::ST_RUN) && (step_q == clns_pkg::StepFirst)))
		else $error("init request did not start at first wake-up strobe");

	a_wait_is_wake: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_ch.valid && (strobe_ch.pre_wait_units != clns_pkg::WaitNone))
		|-> ((strobe_ch.nibble == clns_pkg::NibWake) && !strobe_ch.reg_select
			&& !strobe_ch.extra_settle && !strobe_ch.last_strobe))
		else $error("power-up wait on a strobe other than wake-up");

	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == clns_pkg::ST_IDLE) |=> !$rose(out_valid_q) || $past(emit))
		else $error("strobe produced while idle");
`endif

endmodule

[bench/clns_strobe_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clns_strobe_checker: strobe prediction and in-order compare for the LCD core
// Keeps its own copy of the setup registers from APB writes, turns every
// accepted request into the nibble strobes it must produce, and matches them
// in order against the strobe channel.
// ----------------------------------------------------------------------------
module clns_strobe_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	clns_req_if                         req_ch,
	clns_strobe_if                      strobe_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [clns_pkg::PaddrW-1:0] paddr,
	input  logic [clns_pkg::PdataW-1:0] pwdata,
	output int                          mismatches,
	output int                          outstanding
);

	localparam logic [clns_pkg::NibW-1:0]  WakeNib      = 4'h3;
	localparam logic [clns_pkg::NibW-1:0]  FourBitNib   = 4'h2;
	localparam logic [clns_pkg::ByteW-1:0] ClearDisplay = 8'h01;
	localparam logic [clns_pkg::ByteW-1:0] DdramFlag    = 8'h80;
	localparam logic [clns_pkg::WaitW-1:0] PowerUpWait  = 2'd3;
	localparam logic [clns_pkg::WaitW-1:0] ShortWait    = 2'd1;
	localparam logic [clns_pkg::WaitW-1:0] NoWait       = 2'd0;

	typedef struct packed {
		logic                       rs;
		logic [clns_pkg::NibW-1:0]  nib;
		logic [clns_pkg::WaitW-1:0] wait_units;
		logic                       settle;
		logic                       last;
	} strobe_t;

	strobe_t                    lcd_strobes[$];
	logic [clns_pkg::ByteW-1:0] function_set_q;
	logic [clns_pkg::ByteW-1:0] entry_mode_q;
	logic [clns_pkg::ByteW-1:0] display_control_q;

	// clear, home and the entry-related codes need the long settle
	function automatic logic needs_settle(input logic [clns_pkg::ByteW-1:0] c);
		return (c >= 8'd1) && (c <= 8'd3);
	endfunction

	task automatic queue_strobe(input logic rs, input logic [clns_pkg::NibW-1:0] nib,
			input logic [clns_pkg::WaitW-1:0] wait_units, input logic settle,
			input logic last);
		strobe_t s;
		s.rs         = rs;
		s.nib        = nib;
		s.wait_units = wait_units;
		s.settle     = settle;
		s.last       = last;
		lcd_strobes.push_back(s);
	endtask

	task automatic queue_byte(input logic rs, input logic [clns_pkg::ByteW-1:0] b,
			input logic settle, input logic last);
		queue_strobe(rs, b[7:4], NoWait, 1'b0, 1'b0);
		queue_strobe(rs, b[3:0], NoWait, settle, last);
	endtask

	task automatic expand_request(input logic [clns_pkg::ModeW-1:0] m,
			input logic [clns_pkg::ByteW-1:0] v, input logic [clns_pkg::RowW-1:0] row,
			input logic [clns_pkg::ColW-1:0] col);
		logic [clns_pkg::AddrW-1:0] base;
		logic [clns_pkg::AddrW-1:0] addr;
		logic                       row_ok;
		row_ok = 1'b1;
		base   = '0;
		case (m)
		clns_pkg::MODE_INIT: begin
			queue_strobe(1'b0, WakeNib, PowerUpWait, 1'b0, 1'b0);
			queue_strobe(1'b0, WakeNib, ShortWait, 1'b0, 1'b0);
			queue_strobe(1'b0, WakeNib, ShortWait, 1'b0, 1'b0);
			queue_strobe(1'b0, FourBitNib, NoWait, 1'b0, 1'b0);
			queue_byte(1'b0, function_set_q, needs_settle(function_set_q), 1'b0);
			queue_byte(1'b0, entry_mode_q, needs_settle(entry_mode_q), 1'b0);
			queue_byte(1'b0, display_control_q, needs_settle(display_control_q), 1'b0);
			queue_byte(1'b0, ClearDisplay, 1'b1, 1'b1);
		end
		clns_pkg::MODE_CMD:  queue_byte(1'b0, v, needs_settle(v), 1'b1);
		clns_pkg::MODE_CHAR: queue_byte(1'b1, v, 1'b0, 1'b1);
		clns_pkg::MODE_ADDR: queue_byte(1'b0, v | DdramFlag, 1'b0, 1'b1);
		clns_pkg::MODE_CURSOR: begin
			case (row)
			3'd1: base = 7'h00;
			3'd2: base = 7'h40;
			3'd3: base = 7'h14;
			3'd4: base = 7'h54;
			default: row_ok = 1'b0;
			endcase
			// column is one-based; column 0 and bad rows drop the request
			if (row_ok && col != '0) begin
				addr = base + clns_pkg::AddrW'(col) - 7'd1;
				queue_byte(1'b0, DdramFlag | clns_pkg::ByteW'(addr), 1'b0, 1'b1);
			end
		end
		default: ;
		endcase
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: strobe %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		strobe_t want;
		if (!arst_n) begin
			function_set_q    = 8'h28;
			entry_mode_q      = 8'h06;
			display_control_q = 8'h0E;
			lcd_strobes.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (clns_pkg::reg_idx_t'(paddr[clns_pkg::PaddrW-1:2]))
				clns_pkg::REG_FUNCTION_SET:    function_set_q    = pwdata[clns_pkg::ByteW-1:0];
				clns_pkg::REG_ENTRY_MODE:      entry_mode_q      = pwdata[clns_pkg::ByteW-1:0];
				clns_pkg::REG_DISPLAY_CONTROL:
					display_control_q = pwdata[clns_pkg::ByteW-1:0];
				default: ;
				endcase
			end
			if (strobe_ch.valid && strobe_ch.ready) begin
				if (lcd_strobes.size() == 0) begin
					mismatches++;
					$display("%0t: strobe expected none got rs=%0d nibble=%0h last=%0d",
						$time, strobe_ch.reg_select, strobe_ch.nibble, strobe_ch.last_strobe);
				end else begin
					want = lcd_strobes.pop_front();
					check_field("reg_select", 8'(want.rs), 8'(strobe_ch.reg_select));
					check_field("nibble", 8'(want.nib), 8'(strobe_ch.nibble));
					check_field("pre_wait_units", 8'(want.wait_units),
						8'(strobe_ch.pre_wait_units));
					check_field("extra_settle", 8'(want.settle), 8'(strobe_ch.extra_settle));
					check_field("last_strobe", 8'(want.last), 8'(strobe_ch.last_strobe));
				end
			end
			if (req_ch.valid && req_ch.ready)
				expand_request(req_ch.mode, req_ch.value, req_ch.row, req_ch.column);
		end
		outstanding = lcd_strobes.size();
	end

endmodule

[bench/char_lcd_nibble_sequencer_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core_test: regression bench for the LCD sequencer
// Drives directed and random LCD requests in bursts, stalls the strobe sink in
// several patterns, reprograms the setup registers between phases and leaves
// all strobe checking to the checker module.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core_test;

	localparam int CycleLimit   = 500000;
	localparam int SettleCycles = 4;
	localparam int TailCycles   = 24;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [clns_pkg::PaddrW-1:0] paddr;
	logic [clns_pkg::PdataW-1:0] pwdata;
	logic [clns_pkg::PdataW-1:0] prdata;
	logic                        pready;
	int                          mismatches;
	int                          outstanding;
	int                          cycle_count;
	int                          stall_style;
	int                          stall_tick;

	clns_req_if    req_ch();
	clns_strobe_if strobe_ch();

	char_lcd_nibble_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_ch    (req_ch),
		.strobe_ch (strobe_ch),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	clns_strobe_checker strobe_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_ch      (req_ch),
		.strobe_ch   (strobe_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// strobe sink: always ready, random, periodic, or mostly stalled
	always @(negedge clk) begin
		stall_tick++;
		case (stall_style)
		0:       strobe_ch.ready <= 1'b1;
		1:       strobe_ch.ready <= ($urandom_range(0, 99) < 60);
		2:       strobe_ch.ready <= ((stall_tick % 9) >= 4);
		default: strobe_ch.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	task automatic write_reg(input clns_pkg::reg_idx_t idx,
			input logic [clns_pkg::ByteW-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= clns_pkg::PdataW'(data);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait for every strobe to come out, then reprogram the setup commands
	task automatic drain_then_program(input logic [clns_pkg::ByteW-1:0] fs,
			input logic [clns_pkg::ByteW-1:0] em, input logic [clns_pkg::ByteW-1:0] dc);
		wait (outstanding == 0);
		repeat (SettleCycles) @(posedge clk);
		write_reg(clns_pkg::REG_FUNCTION_SET, fs);
		write_reg(clns_pkg::REG_ENTRY_MODE, em);
		write_reg(clns_pkg::REG_DISPLAY_CONTROL, dc);
	endtask

	task automatic send_req(input logic [clns_pkg::ModeW-1:0] m,
			input logic [clns_pkg::ByteW-1:0] v, input logic [clns_pkg::RowW-1:0] r,
			input logic [clns_pkg::ColW-1:0] c);
		@(negedge clk);
		req_ch.valid  <= 1'b1;
		req_ch.mode   <= m;
		req_ch.value  <= v;
		req_ch.row    <= r;
		req_ch.column <= c;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic pause_sender();
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	task automatic send_random();
		int                         pick;
		logic [clns_pkg::ModeW-1:0] m;
		logic [clns_pkg::ByteW-1:0] v;
		logic [clns_pkg::RowW-1:0]  r;
		logic [clns_pkg::ColW-1:0]  c;
		pick = $urandom_range(0, 99);
		v    = clns_pkg::ByteW'($urandom_range(0, 255));
		r    = clns_pkg::RowW'($urandom_range(0, 7));
		c    = clns_pkg::ColW'($urandom_range(0, 63));
		if (pick < 8) begin
			m = clns_pkg::MODE_INIT;
		end else if (pick < 30) begin
			m = clns_pkg::MODE_CMD;
			if ($urandom_range(0, 3) == 0)
				v = clns_pkg::ByteW'($urandom_range(0, 4));
		end else if (pick < 55) begin
			m = clns_pkg::MODE_CHAR;
		end else if (pick < 72) begin
			m = clns_pkg::MODE_ADDR;
		end else if (pick < 95) begin
			m = clns_pkg::MODE_CURSOR;
			if ($urandom_range(0, 6) != 0)
				r = clns_pkg::RowW'($urandom_range(1, 4));
			if ($urandom_range(0, 11) == 0)
				c = '0;
		end else begin
			m = clns_pkg::ModeW'($urandom_range(clns_pkg::MODE_CURSOR + 1,
				(1 << clns_pkg::ModeW) - 1));
		end
		send_req(m, v, r, c);
	endtask

	task automatic run_phase(input int n, input bit gaps);
		int sent;
		int burst;
		sent = 0;
		while (sent < n) begin
			burst = $urandom_range(1, 12);
			for (int i = 0; i < burst && sent < n; i++) begin
				send_random();
				sent++;
			end
			if (gaps) begin
				pause_sender();
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
		end
		pause_sender();
	endtask

	initial begin
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		req_ch.valid     = 1'b0;
		req_ch.mode      = '0;
		req_ch.value     = '0;
		req_ch.row       = '0;
		req_ch.column    = '0;
		strobe_ch.ready  = 1'b0;
		stall_style      = 1;
		stall_tick       = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed requests with the reset setup commands
		send_req(clns_pkg::MODE_INIT, 8'h00, 3'd0, 6'd0);
		send_req(clns_pkg::MODE_CMD, 8'h00, 3'd0, 6'd0);
		send_req(clns_pkg::MODE_CMD, 8'h01, 3'd7, 6'd63);
		send_req(clns_pkg::MODE_CMD, 8'h02, 3'd0, 6'd0);
		send_req(clns_pkg::MODE_CMD, 8'h03, 3'd0, 6'd0);
		send_req(clns_pkg::MODE_CMD, 8'h04, 3'd0, 6'd0);
		send_req(clns_pkg::MODE_CMD, 8'hFF, 3'd0, 6'd0);
		send_req(clns_pkg::MODE_CHAR, 8'h00, 3'd0, 6'd0);
		send_req(clns_pkg::MODE_CHAR, 8'hFF, 3'd0, 6'd0);
		send_req(clns_pkg::MODE_CHAR, 8'h5A, 3'd0, 6'd0);
		send_req(clns_pkg::MODE_ADDR, 8'h00, 3'd0, 6'd0);
		send_req(clns_pkg::MODE_ADDR, 8'h7F, 3'd0, 6'd0);
		send_req(clns_pkg::MODE_ADDR, 8'hFF, 3'd0, 6'd0);
		send_req(clns_pkg::MODE_CURSOR, 8'h00, 3'd1, 6'd1);
		send_req(clns_pkg::MODE_CURSOR, 8'hFF, 3'd2, 6'd1);
		send_req(clns_pkg::MODE_CURSOR, 8'h00, 3'd3, 6'd20);
		send_req(clns_pkg::MODE_CURSOR, 8'h00, 3'd4, 6'd63);
		send_req(clns_pkg::MODE_CURSOR, 8'h00, 3'd2, 6'd63);
		send_req(clns_pkg::MODE_CURSOR, 8'h00, 3'd0, 6'd5);
		send_req(clns_pkg::MODE_CURSOR, 8'h00, 3'd5, 6'd5);
		send_req(clns_pkg::MODE_CURSOR, 8'h00, 3'd7, 6'd5);
		send_req(clns_pkg::MODE_CURSOR, 8'h00, 3'd1, 6'd0);
		for (int m = clns_pkg::MODE_CURSOR + 1; m < (1 << clns_pkg::ModeW); m++)
			send_req(clns_pkg::ModeW'(m), 8'hA5, 3'd1, 6'd1);
		pause_sender();

		stall_style = 0;
		drain_then_program(8'h00, 8'h00, 8'h00);
		run_phase(65, 1'b1);

		stall_style = 1;
		drain_then_program(8'hFF, 8'hFF, 8'hFF);
		run_phase(65, 1'b0);

		stall_style = 2;
		drain_then_program(8'h01, 8'h02, 8'h03);
		run_phase(65, 1'b1);

		stall_style = 3;
		drain_then_program(clns_pkg::ByteW'($urandom_range(0, 255)),
			clns_pkg::ByteW'($urandom_range(0, 255)),
			clns_pkg::ByteW'($urandom_range(0, 255)));
		run_phase(65, 1'b1);

		stall_style = 2;
		drain_then_program(8'h28, 8'h06, 8'h0E);
		run_phase(65, 1'b0);

		stall_style = 0;
		drain_then_program(clns_pkg::ByteW'($urandom_range(0, 255)),
			clns_pkg::ByteW'($urandom_range(0, 255)),
			clns_pkg::ByteW'($urandom_range(0, 255)));
		run_phase(50, 1'b0);

		wait (outstanding == 0);
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[char_lcd_nibble_sequencer_core.f]
sv/clns_pkg.sv
sv/clns_req_if.sv
sv/clns_strobe_if.sv
sv/char_lcd_nibble_sequencer_core.sv
bench/clns_strobe_checker.sv
bench/char_lcd_nibble_sequencer_core_test.sv
